// ===== rtl/cki_pkg.sv =====
// Shared types, codes and constants of the CRC-keyed index lookup.
`timescale 1ns / 1ps

package cki_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;

    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NAME  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOC_UNIT  = 1'b1;

    localparam int COUNT_W = 11;
    localparam int ALLOC_W = 16;
    localparam logic [ALLOC_W-1:0] ALLOC_RESET = 16'd1;

    localparam logic [31:0] CRC_POLY       = 32'h04C1_1DB7;
    localparam logic [31:0] TAG_ALIGN_MASK = 32'hFFFF_FFFC;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [9:0]       entry_slot;
        logic [31:0]      entry_key;
        logic [31:0]      entry_size;
        logic [31:0]      entry_offset;
        logic [31:0]      entry_tag_offset;
        logic [15:0]      entry_tag_count;
        logic [7:0]       name_byte;
        logic             name_last;
        logic [31:0]      query_key;
    } in_t;

    typedef struct packed {
        logic        found;
        logic [31:0] key;
        logic [31:0] file_size;
        logic [31:0] byte_offset;
        logic [31:0] tag_word_offset;
        logic [15:0] tag_count;
    } out_t;

    // One row of the index table.
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] size;
        logic [31:0] offset;
        logic [31:0] tag_offset;
        logic [15:0] tag_count;
    } entry_t;

    typedef struct packed {
        logic hit;
        logic more;
    } probe_stat_t;

endpackage

// ===== rtl/cki_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cki_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/cki_probe.sv =====
// Binary search step unit: bound update and next probe position.
`timescale 1ns / 1ps

module cki_probe #(
    parameter int MAX_ENTRIES = cki_pkg::MAX_ENTRIES_DEF
) (
    input  logic                             start,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0] n,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0] lo,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0] hp,
    input  logic [$clog2(MAX_ENTRIES)-1:0]   mid,
    input  logic [31:0]                      probe_key,
    input  logic [31:0]                      want,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] lo_next,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] hp_next,
    output logic [$clog2(MAX_ENTRIES)-1:0]   mid_next,
    output cki_pkg::probe_stat_t             stat
);

    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);

    logic [NW:0] span_sum;

    // hp is one past the upper bound, so the window is [lo, hp).
    always_comb begin
        stat.hit = 1'b0;
        lo_next  = lo;
        hp_next  = hp;
        if (start) begin
            lo_next = '0;
            hp_next = n;
        end else if (probe_key == want) begin
            stat.hit = 1'b1;
        end else if (probe_key < want) begin
            lo_next = NW'(mid) + NW'(1);
        end else begin
            hp_next = NW'(mid);
        end
        stat.more = (lo_next < hp_next);
        span_sum  = {1'b0, lo_next} + {1'b0, hp_next} - (NW+1)'(1);
        mid_next  = AW'(span_sum >> 1);
    end

endmodule

// ===== rtl/crc_keyed_index_lookup.sv =====
// Top level: CRC-32 name hashing and binary search over a sorted index table.
// Sequence: a load is written while idle; a name byte is accepted, then hashed one CRC bit per cycle.
// A query runs P probes, P <= clog2(n+1), then waits in the emit step for a free output register;
// a last name byte is hashed before its search starts. One table read per probe sets the pace.
// Throughput: one transaction at a time; s_ready is high only while idle.
// Reset: aresetn (sync, low) clears control, hash, entry_count and alloc unit (1).
`timescale 1ns / 1ps

module crc_keyed_index_lookup #(
    parameter int MAX_ENTRIES = cki_pkg::MAX_ENTRIES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  cki_pkg::in_t                     s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output cki_pkg::out_t                    m_data,
    input  logic                             cfg_we,
    input  logic [cki_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cki_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int NW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);

    // Sequencer codes.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HASH = 2'd1;
    localparam logic [1:0] ST_SRCH = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [2:0] LAST_BIT = 3'd7;

    logic [1:0]                      state_reg;
    logic [2:0]                      bit_cnt_reg;
    logic                            last_reg;
    logic [31:0]                     crc_reg;
    logic [31:0]                     key_reg;
    logic [NW-1:0]                   lo_reg;
    logic [NW-1:0]                   hp_reg;
    logic [AW-1:0]                   mid_reg;
    logic [cki_pkg::COUNT_W-1:0]     count_reg;
    logic [cki_pkg::ALLOC_W-1:0]     alloc_reg;
    cki_pkg::out_t                   res_reg;
    cki_pkg::out_t                   m_data_reg;
    logic                            m_valid_reg;

    logic                            in_acc;
    logic                            start_search;
    logic                            emit_fire;
    cki_pkg::out_t                   emit_data;
    logic [31:0]                     crc_next;
    logic [NW-1:0]                   n_lim;
    logic [NW-1:0]                   lo_next;
    logic [NW-1:0]                   hp_next;
    logic [AW-1:0]                   mid_next;
    cki_pkg::probe_stat_t            stat;
    logic                            ram_we;
    logic                            ram_re;
    cki_pkg::entry_t                 ram_wdata;
    logic [$bits(cki_pkg::entry_t)-1:0] ram_rdata_raw;
    cki_pkg::entry_t                 ram_rdata;
    logic [47:0]                     scaled_offset;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign in_acc  = s_valid && s_ready;

    // Start a search on a query transaction or after the last bit of a final name byte.
    assign start_search =
        (in_acc && (s_data.cmd == cki_pkg::CMD_QUERY)) ||
        ((state_reg == ST_HASH) && (bit_cnt_reg == LAST_BIT) && last_reg);

    // Move the finished result into the output register once it is free.
    assign emit_fire = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    // The result always carries the searched key, hit or miss.
    always_comb begin
        emit_data     = res_reg;
        emit_data.key = key_reg;
    end

    // One MSB-first CRC step per cycle.
    assign crc_next = crc_reg[31] ? ({crc_reg[30:0], 1'b0} ^ cki_pkg::CRC_POLY)
                                  : {crc_reg[30:0], 1'b0};

    // Clamp the searched count to the table depth.
    assign n_lim = (32'(count_reg) > 32'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : NW'(count_reg);

    cki_probe #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_probe (
        .start    (start_search),
        .n        (n_lim),
        .lo       (lo_reg),
        .hp       (hp_reg),
        .mid      (mid_reg),
        .probe_key(ram_rdata.key),
        .want     (key_reg),
        .lo_next  (lo_next),
        .hp_next  (hp_next),
        .mid_next (mid_next),
        .stat     (stat)
    );

    // Drop loads aimed beyond the table depth.
    assign ram_we = in_acc && (s_data.cmd == cki_pkg::CMD_LOAD) &&
                    (32'(s_data.entry_slot) < 32'(MAX_ENTRIES));
    assign ram_wdata.key        = s_data.entry_key;
    assign ram_wdata.size       = s_data.entry_size;
    assign ram_wdata.offset     = s_data.entry_offset;
    assign ram_wdata.tag_offset = s_data.entry_tag_offset;
    assign ram_wdata.tag_count  = s_data.entry_tag_count;

    // Fetch the whole row at every probe so a hit needs no second read.
    assign ram_re = (start_search || ((state_reg == ST_SRCH) && !stat.hit)) && stat.more;

    cki_ram #(
        .WIDTH($bits(cki_pkg::entry_t)),
        .DEPTH(MAX_ENTRIES)
    ) u_table (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(AW'(s_data.entry_slot)),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(mid_next),
        .rdata(ram_rdata_raw)
    );

    assign ram_rdata     = cki_pkg::entry_t'(ram_rdata_raw);
    assign scaled_offset = 48'(ram_rdata.offset) * 48'(alloc_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            last_reg    <= 1'b0;
            crc_reg     <= '0;
            count_reg   <= '0;
            alloc_reg   <= cki_pkg::ALLOC_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            // Configuration writes must arrive only while idle; the block itself does not enforce this.
            if (cfg_we) begin
                unique case (cfg_index)
                    cki_pkg::REG_ENTRY_COUNT: count_reg <= cfg_wdata[cki_pkg::COUNT_W-1:0];
                    cki_pkg::REG_ALLOC_UNIT:  alloc_reg <= cfg_wdata[cki_pkg::ALLOC_W-1:0];
                endcase
            end

            if (emit_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            // Load the search window; with an empty window report not found.
            if (start_search) begin
                lo_reg  <= lo_next;
                hp_reg  <= hp_next;
                mid_reg <= mid_next;
                if (!stat.more) begin
                    res_reg <= '0;
                end
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        case (s_data.cmd)
                            cki_pkg::CMD_NAME: begin
                                crc_reg     <= crc_reg ^ {s_data.name_byte, 24'd0};
                                bit_cnt_reg <= '0;
                                last_reg    <= s_data.name_last;
                                state_reg   <= ST_HASH;
                            end
                            cki_pkg::CMD_QUERY: begin
                                key_reg   <= s_data.query_key;
                                state_reg <= stat.more ? ST_SRCH : ST_EMIT;
                            end
                            default: begin
                                // Loads write the table above; unknown commands drop.
                            end
                        endcase
                    end
                end
                ST_HASH: begin
                    bit_cnt_reg <= bit_cnt_reg + 3'd1;
                    if (bit_cnt_reg == LAST_BIT) begin
                        if (last_reg) begin
                            // Hand the finished hash to the search and clear it.
                            key_reg   <= crc_next;
                            crc_reg   <= '0;
                            state_reg <= stat.more ? ST_SRCH : ST_EMIT;
                        end else begin
                            crc_reg   <= crc_next;
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        crc_reg <= crc_next;
                    end
                end
                ST_SRCH: begin
                    if (stat.hit) begin
                        res_reg.found           <= 1'b1;
                        res_reg.key             <= key_reg;
                        res_reg.file_size       <= ram_rdata.size;
                        res_reg.byte_offset     <= scaled_offset[31:0];
                        res_reg.tag_word_offset <= ram_rdata.tag_offset &
                                                   cki_pkg::TAG_ALIGN_MASK;
                        res_reg.tag_count       <= ram_rdata.tag_count;
                        state_reg               <= ST_EMIT;
                    end else if (stat.more) begin
                        lo_reg  <= lo_next;
                        hp_reg  <= hp_next;
                        mid_reg <= mid_next;
                    end else begin
                        res_reg   <= '0;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // Hold the result until the output register is free.
                    if (emit_fire) begin
                        m_data_reg <= emit_data;
                        state_reg  <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // A result transaction appears only out of the emit step.
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_EMIT))
        else $error("result raised outside emit step");

    // While probing, the window is nonempty and the probe lies inside it.
    a_probe_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SRCH) |->
            (lo_reg < hp_reg) && (NW'(mid_reg) >= lo_reg) && (NW'(mid_reg) < hp_reg))
        else $error("probe outside search window");

    // A miss carries zero payload fields.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.found) |->
            (m_data_reg.file_size == 32'd0) && (m_data_reg.byte_offset == 32'd0) &&
            (m_data_reg.tag_word_offset == 32'd0) && (m_data_reg.tag_count == 16'd0))
        else $error("miss result with nonzero fields");

    // The name hash restarts from zero after a final byte.
    a_hash_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_HASH) && (bit_cnt_reg == LAST_BIT) && last_reg) |=>
            (crc_reg == 32'd0))
        else $error("name hash not cleared after final byte");

endmodule
